// ===== rtl/smi_pkg.sv =====
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types and constants of the stack machine interpreter.
// ----------------------------------------------------------------------------
package smi_pkg;

    localparam int SMI_STACK_DEPTH = 64;
    localparam int DATA_W          = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS       = DATA_W;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);

    localparam logic [3:0] OP_CONST = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_MAX   = 4'd5;
    localparam logic [3:0] OP_MIN   = 4'd6;
    localparam logic [3:0] OP_NEG   = 4'd7;
    localparam logic [3:0] OP_DUP   = 4'd8;
    localparam logic [3:0] OP_SWAP  = 4'd9;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_OVER    = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    typedef enum logic [2:0] {
        K_PUSH,
        K_NEG,
        K_DUP,
        K_PAIR,
        K_BAD
    } t_kind;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MAX,
        ALU_MIN,
        ALU_SWAP
    } t_alu;

    typedef struct packed {
        t_kind             kind;
        t_alu              alu;
        logic [DATA_W-1:0] imm;
    } t_instr;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [1:0] {
        S_FETCH,
        S_OPER,
        S_DIV
    } t_state;

endpackage

// ===== rtl/smi_front.sv =====
// ----------------------------------------------------------------------------
// smi_front
// Accepts instruction words and classifies each opcode for the queue.
// ----------------------------------------------------------------------------
module smi_front import smi_pkg::*; (
    input  logic              i_in_valid,
    input  logic [3:0]        i_mode,
    input  logic [DATA_W-1:0] i_push_value,
    input  logic              i_q_full,
    output logic              o_in_ready,
    output logic              o_q_push,
    output t_instr            o_q_instr
);

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_q_instr.imm  = i_push_value;
        o_q_instr.kind = K_PAIR;
        o_q_instr.alu  = ALU_ADD;
        case (i_mode)
            OP_CONST: o_q_instr.kind = K_PUSH;
            OP_ADD:   o_q_instr.alu  = ALU_ADD;
            OP_SUB:   o_q_instr.alu  = ALU_SUB;
            OP_MUL:   o_q_instr.alu  = ALU_MUL;
            OP_DIV:   o_q_instr.alu  = ALU_DIV;
            OP_MAX:   o_q_instr.alu  = ALU_MAX;
            OP_MIN:   o_q_instr.alu  = ALU_MIN;
            OP_NEG:   o_q_instr.kind = K_NEG;
            OP_DUP:   o_q_instr.kind = K_DUP;
            OP_SWAP:  o_q_instr.alu  = ALU_SWAP;
            default:  o_q_instr.kind = K_BAD;
        endcase
    end

endmodule

// ===== rtl/smi_fifo.sv =====
// ----------------------------------------------------------------------------
// smi_fifo
// Short instruction queue between the front and the execution unit.
// ----------------------------------------------------------------------------
module smi_fifo import smi_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_instr i_instr,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_instr o_instr
);

    t_instr              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic                do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_instr = r_slots[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_instr;
        end
    end

endmodule

// ===== rtl/smi_divider.sv =====
// ----------------------------------------------------------------------------
// smi_divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smi_divider import smi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_busy,
    output logic [DATA_W-1:0] o_quotient
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W:0]      r_rem;
    logic [DATA_W-1:0]    r_dvs;
    logic [DATA_W:0]      rem_shift;
    logic [DATA_W:0]      diff;

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;
    assign rem_shift  = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign diff       = rem_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (o_busy) begin
            if (!diff[DATA_W]) begin
                r_rem <= diff;
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_shift;
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/smi_exec.sv =====
// ----------------------------------------------------------------------------
// smi_exec
// Execution unit: stack storage, arithmetic, sequencing and result register.
// ----------------------------------------------------------------------------
module smi_exec import smi_pkg::*; #(
    parameter int STACK_DEPTH = SMI_STACK_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  t_instr                           i_q_instr,
    output logic                             o_q_pop,
    output t_div_req                         o_div_req,
    input  logic                             i_div_busy,
    input  logic [DATA_W-1:0]                i_div_quotient,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [DATA_W-1:0]                o_top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_depth,
    output logic [2:0]                       o_status
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    t_state            r_state, n_state;
    logic [SPW-1:0]    r_sp, n_sp;
    logic [DATA_W-1:0] r_tos, n_tos;
    t_alu              r_alu, n_alu;
    logic              r_neg, n_neg;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_top;
    logic [SPW-1:0]    r_out_depth;
    logic [2:0]        r_out_status;

    logic              out_free;
    logic              done;
    logic [2:0]        res_status;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              rd_en;
    logic [SPW-1:0]    sp_m1;
    logic [SPW-1:0]    sp_m2;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    logic [DATA_W-1:0] alu_res;
    logic              a_lt_b;

    assign out_free = !r_out_valid || i_out_ready;
    assign sp_m1    = r_sp - SPW'(1);
    assign sp_m2    = r_sp - SPW'(2);
    assign op_a     = r_tos;
    assign op_b     = r_rd_data;
    assign a_lt_b   = ($signed(op_a) < $signed(op_b));

    always_comb begin
        case (r_alu)
            ALU_ADD: alu_res = op_a + op_b;
            ALU_SUB: alu_res = op_a - op_b;
            ALU_MUL: alu_res = op_a * op_b;
            ALU_MAX: alu_res = a_lt_b ? op_b : op_a;
            ALU_MIN: alu_res = a_lt_b ? op_a : op_b;
            default: alu_res = op_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FETCH;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        r_alu <= n_alu;
        r_neg <= n_neg;
    end

    always_comb begin
        n_state            = r_state;
        n_sp               = r_sp;
        n_tos              = r_tos;
        n_alu              = r_alu;
        n_neg              = r_neg;
        o_q_pop            = 1'b0;
        done               = 1'b0;
        res_status         = ST_OK;
        mem_we             = 1'b0;
        mem_waddr          = sp_m1[AW-1:0];
        mem_wdata          = r_tos;
        rd_en              = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = op_a[DATA_W-1] ? (DATA_W'(0) - op_a) : op_a;
        o_div_req.divisor  = op_b[DATA_W-1] ? (DATA_W'(0) - op_b) : op_b;
        case (r_state)
            S_FETCH: begin
                if (i_q_valid) begin
                    case (i_q_instr.kind)
                        K_PUSH: begin
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                done    = 1'b1;
                                if (r_sp == SPW'(STACK_DEPTH)) begin
                                    res_status = ST_OVER;
                                end else begin
                                    mem_we = (r_sp != '0);
                                    n_tos  = i_q_instr.imm;
                                    n_sp   = r_sp + SPW'(1);
                                end
                            end
                        end
                        K_NEG: begin
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                done    = 1'b1;
                                if (r_sp == '0) begin
                                    res_status = ST_UNDER;
                                end else begin
                                    n_tos = DATA_W'(0) - r_tos;
                                end
                            end
                        end
                        K_DUP: begin
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                done    = 1'b1;
                                if (r_sp == '0) begin
                                    res_status = ST_UNDER;
                                end else if (r_sp == SPW'(STACK_DEPTH)) begin
                                    res_status = ST_OVER;
                                end else begin
                                    mem_we = 1'b1;
                                    n_sp   = r_sp + SPW'(1);
                                end
                            end
                        end
                        K_PAIR: begin
                            if (r_sp < SPW'(2)) begin
                                if (out_free) begin
                                    o_q_pop    = 1'b1;
                                    done       = 1'b1;
                                    res_status = ST_UNDER;
                                end
                            end else begin
                                o_q_pop = 1'b1;
                                rd_en   = 1'b1;
                                n_alu   = i_q_instr.alu;
                                n_state = S_OPER;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                o_q_pop    = 1'b1;
                                done       = 1'b1;
                                res_status = ST_UNKNOWN;
                            end
                        end
                    endcase
                end
            end
            S_OPER: begin
                if (r_alu == ALU_DIV) begin
                    if (op_b == '0) begin
                        if (out_free) begin
                            done       = 1'b1;
                            res_status = ST_DIVZERO;
                            n_state    = S_FETCH;
                        end
                    end else begin
                        o_div_req.start = 1'b1;
                        n_neg           = op_a[DATA_W-1] ^ op_b[DATA_W-1];
                        n_state         = S_DIV;
                    end
                end else if (out_free) begin
                    done    = 1'b1;
                    n_state = S_FETCH;
                    if (r_alu == ALU_SWAP) begin
                        mem_we    = 1'b1;
                        mem_waddr = sp_m2[AW-1:0];
                        n_tos     = op_b;
                    end else begin
                        n_tos = alu_res;
                        n_sp  = sp_m1;
                    end
                end
            end
            S_DIV: begin
                if (!i_div_busy && out_free) begin
                    done    = 1'b1;
                    n_state = S_FETCH;
                    n_tos   = r_neg ? (DATA_W'(0) - i_div_quotient) : i_div_quotient;
                    n_sp    = sp_m1;
                end
            end
            default: begin
                n_state = S_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[sp_m2[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_top    <= (n_sp == '0) ? '0 : n_tos;
            r_out_depth  <= n_sp;
            r_out_status <= res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_top_value = r_out_top;
    assign o_depth     = r_out_depth;
    assign o_status    = r_out_status;

endmodule

// ===== rtl/stack_machine_interpreter.sv =====
// ----------------------------------------------------------------------------
// stack_machine_interpreter
// Executes one stack-machine instruction per input word and returns the new
// top of stack, the depth and a status word for each.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_mode, i_push_value
//   out      output     o_out_valid / i_out_ready o_top_value, o_depth, o_status
//
// CONST, NEG, DUP, unknown opcodes and every underflow or overflow complete
// in the fetch state of the execution unit; the binary operations, SWAP and
// a division by zero first wait for the registered read of the stack memory.
// DIV then hands its magnitudes to the one-bit-per-cycle divider. A two-entry
// queue lets input words be taken while the execution unit works or the
// output stalls. Reset is synchronous; the stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
module stack_machine_interpreter import smi_pkg::*; #(
    parameter int STACK_DEPTH = SMI_STACK_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [3:0]                       i_mode,
    input  logic signed [DATA_W-1:0]         i_push_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [DATA_W-1:0]         o_top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_depth,
    output logic [2:0]                       o_status
);

    logic              q_full;
    logic              q_push;
    t_instr            q_in;
    logic              q_valid;
    t_instr            q_out;
    logic              q_pop;
    t_div_req          div_req;
    logic              div_busy;
    logic [DATA_W-1:0] div_quotient;
    logic [DATA_W-1:0] top_value;

    smi_front u_front (
        .i_in_valid   (i_in_valid),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .i_q_full     (q_full),
        .o_in_ready   (o_in_ready),
        .o_q_push     (q_push),
        .o_q_instr    (q_in)
    );

    smi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_instr (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_instr (q_out)
    );

    smi_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_busy     (div_busy),
        .o_quotient (div_quotient)
    );

    smi_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_instr      (q_out),
        .o_q_pop        (q_pop),
        .o_div_req      (div_req),
        .i_div_busy     (div_busy),
        .i_div_quotient (div_quotient),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_top_value    (top_value),
        .o_depth        (o_depth),
        .o_status       (o_status)
    );

    assign o_top_value = $signed(top_value);

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_depth <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH)))
        else $error("Reported depth exceeds the stack size.");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_depth == '0)) |-> (o_top_value == '0))
        else $error("Empty stack reports a non-zero top.");

    a_under_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_UNDER)) |->
            (o_depth < ($clog2(STACK_DEPTH+1))'(2)))
        else $error("Underflow reported with two or more entries.");

    a_over_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OVER)) |->
            (o_depth == ($clog2(STACK_DEPTH+1))'(STACK_DEPTH)))
        else $error("Overflow reported on a stack that is not full.");

endmodule

// ===== sim/tb_stack_machine_interpreter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_machine_interpreter
// Self-checking testbench for the stack machine interpreter. A short table of
// instruction words covers the error cases, the wrap-around corners and every
// opcode. It is followed by about a thousand random words, shaped into phases
// that grow, drain or scramble the stack. Each word is run through a
// behavioural model of the stack when it is accepted. Every returned word is
// compared field by field with the oldest prediction, while both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_stack_machine_interpreter;
    import smi_pkg::*;

    localparam int DEPTH_W = $clog2(SMI_STACK_DEPTH + 1);
    localparam int N_ROWS  = 24;
    localparam int N_RANDOM = 1000;

    localparam logic [3:0] OP_UNKNOWN_LO = 4'd10;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

    typedef struct packed {
        logic signed [DATA_W-1:0] top;
        logic [DEPTH_W-1:0]       depth;
        logic [2:0]               status;
    } t_result;

    typedef struct packed {
        logic [3:0]        op;
        logic [DATA_W-1:0] imm;
        logic              typed;
        t_result           want;
    } t_row;

    typedef enum logic [1:0] {
        PH_GROW,
        PH_SHRINK,
        PH_MIXED,
        PH_NOISE
    } t_phase;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [3:0]               i_mode;
    logic signed [DATA_W-1:0] i_push_value;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_top_value;
    logic [DEPTH_W-1:0]       o_depth;
    logic [2:0]               o_status;

    logic [DATA_W-1:0] stack_image [SMI_STACK_DEPTH];
    int                stack_level = 0;
    t_result           pending_results [$];
    int                mismatch_count = 0;
    int                words_sent = 0;
    int                status_tally [5] = '{0, 0, 0, 0, 0};
    int                deepest = 0;
    int                burst_left = 0;
    logic [9:0]        sink_tick = '0;

    t_row directed_rows [N_ROWS] = '{
        '{OP_ADD,        32'h0000_0000, 1'b1, '{32'sh0000_0000, 7'd0, ST_UNDER}},
        '{OP_NEG,        32'h0000_0000, 1'b1, '{32'sh0000_0000, 7'd0, ST_UNDER}},
        '{OP_DUP,        32'h0000_0000, 1'b1, '{32'sh0000_0000, 7'd0, ST_UNDER}},
        '{OP_SWAP,       32'hFFFF_FFFF, 1'b1, '{32'sh0000_0000, 7'd0, ST_UNDER}},
        '{OP_UNKNOWN_LO, 32'h0000_0000, 1'b1, '{32'sh0000_0000, 7'd0, ST_UNKNOWN}},
        '{OP_UNKNOWN_HI, 32'hFFFF_FFFF, 1'b1, '{32'sh0000_0000, 7'd0, ST_UNKNOWN}},
        '{OP_CONST,      32'hFFFF_FFFF, 1'b1, '{32'shFFFF_FFFF, 7'd1, ST_OK}},
        '{OP_MUL,        32'h0000_0000, 1'b1, '{32'shFFFF_FFFF, 7'd1, ST_UNDER}},
        '{OP_CONST,      32'h8000_0000, 1'b1, '{32'sh8000_0000, 7'd2, ST_OK}},
        '{OP_DIV,        32'h0000_0000, 1'b1, '{32'sh8000_0000, 7'd1, ST_OK}},
        '{OP_NEG,        32'h0000_0000, 1'b1, '{32'sh8000_0000, 7'd1, ST_OK}},
        '{OP_CONST,      32'h0000_0000, 1'b1, '{32'sh0000_0000, 7'd2, ST_OK}},
        '{OP_SWAP,       32'h0000_0000, 1'b1, '{32'sh8000_0000, 7'd2, ST_OK}},
        '{OP_DIV,        32'h0000_0000, 1'b1, '{32'sh8000_0000, 7'd2, ST_DIVZERO}},
        '{OP_CONST,      32'h7FFF_FFFF, 1'b1, '{32'sh7FFF_FFFF, 7'd3, ST_OK}},
        '{OP_SUB,        32'h0000_0000, 1'b0, '0},
        '{OP_MAX,        32'h0000_0000, 1'b0, '0},
        '{OP_CONST,      32'h0000_0007, 1'b1, '{32'sh0000_0007, 7'd2, ST_OK}},
        '{OP_DUP,        32'h0000_0000, 1'b0, '0},
        '{OP_MUL,        32'h0000_0000, 1'b0, '0},
        '{OP_CONST,      32'hFFFF_FFFD, 1'b0, '0},
        '{OP_MIN,        32'h0000_0000, 1'b0, '0},
        '{OP_ADD,        32'h0000_0000, 1'b0, '0},
        '{OP_DIV,        32'h0000_0000, 1'b0, '0}
    };

    stack_machine_interpreter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_top_value  (o_top_value),
        .o_depth      (o_depth),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result eval_instruction(input logic [3:0] op,
                                                 input logic [DATA_W-1:0] imm);
        t_result           res;
        logic [DATA_W-1:0] a, b, r, ma, mb, q;
        logic [2:0]        st;
        st = ST_OK;
        a  = '0;
        b  = '0;
        r  = '0;
        if (op > OP_SWAP) begin
            st = ST_UNKNOWN;
        end else if (op == OP_CONST) begin
            if (stack_level >= SMI_STACK_DEPTH) begin
                st = ST_OVER;
            end else begin
                stack_image[stack_level] = imm;
                stack_level++;
            end
        end else if (op == OP_NEG || op == OP_DUP) begin
            if (stack_level < 1) begin
                st = ST_UNDER;
            end else if (op == OP_NEG) begin
                stack_image[stack_level-1] = 32'd0 - stack_image[stack_level-1];
            end else if (stack_level >= SMI_STACK_DEPTH) begin
                st = ST_OVER;
            end else begin
                stack_image[stack_level] = stack_image[stack_level-1];
                stack_level++;
            end
        end else if (stack_level < 2) begin
            st = ST_UNDER;
        end else begin
            a = stack_image[stack_level-1];
            b = stack_image[stack_level-2];
            case (op)
                OP_ADD: r = a + b;
                OP_SUB: r = a - b;
                OP_MUL: r = a * b;
                OP_DIV: begin
                    if (b == '0) begin
                        st = ST_DIVZERO;
                    end else begin
                        ma = a[DATA_W-1] ? (32'd0 - a) : a;
                        mb = b[DATA_W-1] ? (32'd0 - b) : b;
                        q  = ma / mb;
                        r  = (a[DATA_W-1] ^ b[DATA_W-1]) ? (32'd0 - q) : q;
                    end
                end
                OP_MAX: r = ($signed(a) < $signed(b)) ? b : a;
                OP_MIN: r = ($signed(a) < $signed(b)) ? a : b;
                default: r = '0;
            endcase
            if (st == ST_OK) begin
                if (op == OP_SWAP) begin
                    stack_image[stack_level-1] = b;
                    stack_image[stack_level-2] = a;
                end else begin
                    stack_image[stack_level-2] = r;
                    stack_level--;
                end
            end
        end
        res.top    = (stack_level > 0) ? stack_image[stack_level-1] : '0;
        res.depth  = stack_level[DEPTH_W-1:0];
        res.status = st;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'(signed'($urandom_range(0, 31)) - 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_opcode(input t_phase phase);
        int r;
        r = $urandom_range(0, 9);
        case (phase)
            PH_GROW: begin
                if (r < 6) return OP_CONST;
                if (r < 8) return OP_DUP;
                if (r == 8) return OP_NEG;
                return OP_SWAP;
            end
            PH_SHRINK: begin
                case (r)
                    0: return OP_CONST;
                    1: return OP_ADD;
                    2: return OP_SUB;
                    3: return OP_MUL;
                    4, 5: return OP_DIV;
                    6: return OP_MAX;
                    7: return OP_MIN;
                    8: return OP_NEG;
                    default: return OP_SWAP;
                endcase
            end
            PH_MIXED: return 4'($urandom_range(OP_CONST, OP_SWAP));
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    // Holds the word on the channel until it is taken, opening an idle gap
    // whenever the current burst runs out, unless the random gap drawn is zero.
    task automatic offer_word(input logic [3:0] op, input logic [DATA_W-1:0] imm);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= op;
        i_push_value <= imm;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        words_sent++;
    endtask

    task automatic log_prediction(input t_result res);
        pending_results.push_back(res);
        status_tally[res.status]++;
        if (res.depth > deepest) deepest = res.depth;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        sink_tick <= sink_tick + 1'b1;
        case (sink_tick[9:8])
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: i_out_ready <= (sink_tick[3:0] < 4'd11);
            default: i_out_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, top %0d depth %0d status %0d",
                         $realtime, o_top_value, o_depth, o_status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_top_value !== want.top) begin
                    $display("%0t: top_value expected %0d, got %0d",
                             $realtime, want.top, o_top_value);
                    mismatch_count++;
                end
                if (o_depth !== want.depth) begin
                    $display("%0t: depth expected %0d, got %0d",
                             $realtime, want.depth, o_depth);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $realtime, want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_result    res;
        t_phase     phase;
        int         phase_left;
        logic [3:0] op;
        logic [DATA_W-1:0] imm;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_mode       <= OP_CONST;
        i_push_value <= '0;
        phase        = PH_GROW;
        phase_left   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            offer_word(directed_rows[i].op, directed_rows[i].imm);
            res = eval_instruction(directed_rows[i].op, directed_rows[i].imm);
            log_prediction(directed_rows[i].typed ? directed_rows[i].want : res);
        end
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 5))
                    0, 1: phase = PH_GROW;
                    2: phase = PH_SHRINK;
                    3, 4: phase = PH_MIXED;
                    default: phase = PH_NOISE;
                endcase
                phase_left = $urandom_range(20, 90);
            end
            phase_left--;
            if (n == N_RANDOM / 2) wait_drained();
            op  = pick_opcode(phase);
            imm = pick_value();
            offer_word(op, imm);
            log_prediction(eval_instruction(op, imm));
        end

        wait_drained();
        repeat (DIV_STEPS + 32) @(posedge i_clk);

        $display("Sent %0d words: %0d ok, %0d underflow, %0d overflow, %0d divide by zero,",
                 words_sent, status_tally[ST_OK], status_tally[ST_UNDER],
                 status_tally[ST_OVER], status_tally[ST_DIVZERO]);
        $display("%0d unknown opcode; the stack reached a depth of %0d.",
                 status_tally[ST_UNKNOWN], deepest);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d words outstanding.", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
